// ===== sv/smsa_pkg.sv =====
package smsa_pkg;

    localparam int NUM_DOFS_DEF      = 4096;
    localparam int NUM_EQUATIONS_DEF = 4096;
    localparam int NUM_NONZEROS_DEF  = 65536;

    localparam int WORD_W  = 18;
    localparam int VALUE_W = 64;
    localparam int IN_W    = 192;
    localparam int OUT_W   = 136;

    typedef enum logic [2:0] {
        OP_WR_MAP = 3'd0,
        OP_WR_PTR = 3'd1,
        OP_WR_ROW = 3'd2,
        OP_ACC    = 3'd3,
        OP_RD_VAL = 3'd4,
        OP_WR_VAL = 3'd5
    } op_t;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== sv/smsa_ram.sv =====
module smsa_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [smsa_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [smsa_pkg::addr_w(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/smsa_fadd.sv =====
module smsa_fadd (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    typedef enum logic [1:0] {F_IDLE, F_ADD, F_NORM, F_ROUND} fstate_t;

    fstate_t      state_reg;
    logic         done_reg;
    logic [63:0]  result_reg;
    logic         sign_reg;
    logic         sub_reg;
    logic         zsign_reg;
    logic [11:0]  x_reg;
    logic [11:0]  d_reg;
    logic [55:0]  mbig_reg;
    logic [55:0]  msmall_reg;
    logic [55:0]  m_reg;

    logic         a_nan, b_nan, a_inf, b_inf, a_big;
    logic [63:0]  hi, lo;
    logic [55:0]  sh, sh_mask;
    logic         sticky;
    logic [56:0]  sum;
    logic [55:0]  m_add;
    logic [11:0]  x_add;
    logic         up;
    logic [53:0]  mant;
    logic [53:0]  mant_n;
    logic [11:0]  x_rnd;

    assign a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    assign b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    assign a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    assign b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    assign a_big = (a[62:0] >= b[62:0]);
    assign hi    = a_big ? a : b;
    assign lo    = a_big ? b : a;

    always_comb
    begin
        sh_mask = 56'd0;
        sh      = 56'd0;
        sticky  = 1'b0;
        if (d_reg >= 12'd56)
        begin
            sticky = |msmall_reg;
        end
        else
        begin
            sh_mask = (56'd1 << d_reg[5:0]) - 56'd1;
            sh      = msmall_reg >> d_reg[5:0];
            sticky  = |(msmall_reg & sh_mask);
        end
        if (sub_reg)
        begin
            sum = {1'b0, mbig_reg} - {1'b0, sh | {55'd0, sticky}};
        end
        else
        begin
            sum = {1'b0, mbig_reg} + {1'b0, sh | {55'd0, sticky}};
        end
        if (sum[56])
        begin
            m_add = {sum[56:2], sum[1] | sum[0]};
            x_add = x_reg + 12'd1;
        end
        else
        begin
            m_add = sum[55:0];
            x_add = x_reg;
        end
    end

    // Round to nearest, ties to even, on guard, round and sticky bits.
    always_comb
    begin
        up     = m_reg[2] && (m_reg[1] || m_reg[0] || m_reg[3]);
        mant   = {1'b0, m_reg[55:3]} + {53'd0, up};
        mant_n = mant;
        x_rnd  = x_reg;
        if (mant[53])
        begin
            mant_n = mant >> 1;
            x_rnd  = x_reg + 12'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        if (a_nan)
                        begin
                            result_reg <= a | 64'h0008_0000_0000_0000;
                            done_reg   <= 1'b1;
                        end
                        else if (b_nan)
                        begin
                            result_reg <= b | 64'h0008_0000_0000_0000;
                            done_reg   <= 1'b1;
                        end
                        else if (a_inf && b_inf && (a[63] != b[63]))
                        begin
                            result_reg <= 64'hFFF8_0000_0000_0000;
                            done_reg   <= 1'b1;
                        end
                        else if (a_inf)
                        begin
                            result_reg <= a;
                            done_reg   <= 1'b1;
                        end
                        else if (b_inf)
                        begin
                            result_reg <= b;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            sign_reg   <= hi[63];
                            sub_reg    <= a[63] ^ b[63];
                            zsign_reg  <= a[63] & b[63];
                            x_reg      <= (hi[62:52] == 11'd0) ? 12'd1 : {1'b0, hi[62:52]};
                            d_reg      <= ((hi[62:52] == 11'd0) ? 12'd1 : {1'b0, hi[62:52]})
                                        - ((lo[62:52] == 11'd0) ? 12'd1 : {1'b0, lo[62:52]});
                            mbig_reg   <= {(hi[62:52] != 11'd0), hi[51:0], 3'b000};
                            msmall_reg <= {(lo[62:52] != 11'd0), lo[51:0], 3'b000};
                            state_reg  <= F_ADD;
                        end
                    end
                end
                F_ADD:
                begin
                    if (m_add == 56'd0)
                    begin
                        result_reg <= {zsign_reg, 63'd0};
                        done_reg   <= 1'b1;
                        state_reg  <= F_IDLE;
                    end
                    else
                    begin
                        m_reg     <= m_add;
                        x_reg     <= x_add;
                        state_reg <= F_NORM;
                    end
                end
                F_NORM:
                begin
                    if (!m_reg[55] && (x_reg > 12'd1))
                    begin
                        m_reg <= m_reg << 1;
                        x_reg <= x_reg - 12'd1;
                    end
                    else
                    begin
                        state_reg <= F_ROUND;
                    end
                end
                F_ROUND:
                begin
                    if (x_rnd >= 12'd2047)
                    begin
                        result_reg <= {sign_reg, 11'h7FF, 52'd0};
                    end
                    else
                    begin
                        result_reg <= {sign_reg, mant_n[52] ? x_rnd[10:0] : 11'd0,
                                       mant_n[51:0]};
                    end
                    done_reg  <= 1'b1;
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/sparse_matrix_scatter_accumulate.sv =====
// Table writes and value writes give their result in the cycle after the item is taken;
// a value read passes S_VRD. An accumulate reads map (S_MAP_R, S_MAP_C) and pointers
// (S_PTR0, S_PTR1), then S_SCAN and S_CMP per stored row searched (S_SCAN again on a
// miss), the value in S_VAL, then two passes of the shared double adder, timed by its
// normalize loop. One item is in work at a time; the next is taken once the result is
// accepted. After reset the value store is cleared one entry a cycle.
module sparse_matrix_scatter_accumulate #(
    parameter int NUM_DOFS      = smsa_pkg::NUM_DOFS_DEF,
    parameter int NUM_EQUATIONS = smsa_pkg::NUM_EQUATIONS_DEF,
    parameter int NUM_NONZEROS  = smsa_pkg::NUM_NONZEROS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // operation, table_address, table_word, row_dof, col_dof, value_real, value_imag
    input  logic [smsa_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status, read_real, read_imag
    output logic [smsa_pkg::OUT_W-1:0]  m_tdata
);

    localparam int DA = smsa_pkg::addr_w(NUM_DOFS);
    localparam int PA = smsa_pkg::addr_w(NUM_EQUATIONS + 1);
    localparam int NA = smsa_pkg::addr_w(NUM_NONZEROS);
    localparam int WW = smsa_pkg::WORD_W;
    localparam int VW = smsa_pkg::VALUE_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MAP_R, S_MAP_C, S_PTR0, S_PTR1,
        S_SCAN, S_CMP, S_VAL, S_ADD_RE, S_ADD_IM, S_VRD
    } state_t;

    state_t                state_reg;
    logic [NA-1:0]         clr_cnt_reg;
    logic                  m_tvalid_reg;
    logic [1:0]            status_reg;
    logic [VW-1:0]         rre_reg, rim_reg;
    logic [11:0]           rdof_reg, cdof_reg;
    logic [VW-1:0]         vre_reg, vim_reg;
    logic signed [WW-1:0]  mrow_reg;
    logic [PA-1:0]         mcol_reg;
    logic signed [WW:0]    pos_reg, stop_reg;
    logic [NA-1:0]         e_reg;
    logic [VW-1:0]         acc_im_reg, re_res_reg;

    logic [2:0]            in_op;
    logic [15:0]           in_addr;
    logic [WW-1:0]         in_word;
    logic [11:0]           in_rdof, in_cdof;
    logic [VW-1:0]         in_vre, in_vim;
    logic                  accept;
    logic [31:0]           addr32, rdof32, cdof32;
    logic signed [31:0]    mcol32, e32;
    logic signed [WW:0]    e19, want;

    logic                  map_we, ptr_we, row_we, val_we;
    logic [DA-1:0]         map_raddr;
    logic [PA-1:0]         ptr_raddr;
    logic [NA-1:0]         row_raddr, val_raddr, val_waddr;
    logic [WW-1:0]         map_rdata, ptr_rdata, row_rdata;
    logic [2*VW-1:0]       val_rdata, val_wdata;

    logic                  fadd_start, fadd_done;
    logic [VW-1:0]         fadd_a, fadd_b, fadd_res;

    assign in_op   = s_tdata[2:0];
    assign in_addr = s_tdata[18:3];
    assign in_word = s_tdata[36:19];
    assign in_rdof = s_tdata[48:37];
    assign in_cdof = s_tdata[60:49];
    assign in_vre  = s_tdata[124:61];
    assign in_vim  = s_tdata[188:125];

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;

    assign addr32 = {16'd0, in_addr};
    assign rdof32 = {20'd0, in_rdof};
    assign cdof32 = {20'd0, cdof_reg};
    assign mcol32 = {{(32 - WW){map_rdata[WW-1]}}, map_rdata};
    assign e19    = pos_reg - 19'sd1;
    assign e32    = {{(32 - WW - 1){e19[WW]}}, e19};
    assign want   = {mrow_reg[WW-1], mrow_reg} + 19'sd1;

    always_comb
    begin
        map_we    = accept && (in_op == smsa_pkg::OP_WR_MAP) && (addr32 < NUM_DOFS);
        ptr_we    = accept && (in_op == smsa_pkg::OP_WR_PTR) && (addr32 < NUM_EQUATIONS + 1);
        row_we    = accept && (in_op == smsa_pkg::OP_WR_ROW) && (addr32 < NUM_NONZEROS);
        map_raddr = (state_reg == S_IDLE) ? rdof32[DA-1:0] : cdof32[DA-1:0];
        ptr_raddr = (state_reg == S_MAP_C) ? mcol32[PA-1:0] : mcol_reg + 1'b1;
        row_raddr = e32[NA-1:0];
        val_raddr = (state_reg == S_IDLE) ? addr32[NA-1:0] : e_reg;
        val_we    = 1'b0;
        val_waddr = e_reg;
        val_wdata = {fadd_res, re_res_reg};
        if (state_reg == S_CLEAR)
        begin
            val_we    = 1'b1;
            val_waddr = clr_cnt_reg;
            val_wdata = '0;
        end
        else if (state_reg == S_IDLE)
        begin
            val_we    = accept && (in_op == smsa_pkg::OP_WR_VAL) && (addr32 < NUM_NONZEROS);
            val_waddr = addr32[NA-1:0];
            val_wdata = {in_vim, in_vre};
        end
        else if (state_reg == S_ADD_IM)
        begin
            val_we = fadd_done;
        end
        fadd_start = (state_reg == S_VAL) || ((state_reg == S_ADD_RE) && fadd_done);
        fadd_a     = (state_reg == S_VAL) ? val_rdata[VW-1:0] : acc_im_reg;
        fadd_b     = (state_reg == S_VAL) ? vre_reg : vim_reg;
    end

    smsa_ram #(.WIDTH(WW), .DEPTH(NUM_DOFS)) u_map (
        .clk(clk), .we(map_we), .waddr(addr32[DA-1:0]), .wdata(in_word),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    smsa_ram #(.WIDTH(WW), .DEPTH(NUM_EQUATIONS + 1)) u_ptr (
        .clk(clk), .we(ptr_we), .waddr(addr32[PA-1:0]), .wdata(in_word),
        .raddr(ptr_raddr), .rdata(ptr_rdata)
    );

    smsa_ram #(.WIDTH(WW), .DEPTH(NUM_NONZEROS)) u_row (
        .clk(clk), .we(row_we), .waddr(addr32[NA-1:0]), .wdata(in_word),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    smsa_ram #(.WIDTH(2 * VW), .DEPTH(NUM_NONZEROS)) u_val (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    smsa_fadd u_fadd (
        .clk(clk), .rst_n(rst_n), .start(fadd_start), .a(fadd_a), .b(fadd_b),
        .done(fadd_done), .result(fadd_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == NA'(NUM_NONZEROS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rdof_reg   <= in_rdof;
                        cdof_reg   <= in_cdof;
                        vre_reg    <= in_vre;
                        vim_reg    <= in_vim;
                        rre_reg    <= '0;
                        rim_reg    <= '0;
                        case (in_op)
                            smsa_pkg::OP_WR_MAP:
                            begin
                                status_reg   <= map_we ? smsa_pkg::ST_DONE : smsa_pkg::ST_RANGE;
                                m_tvalid_reg <= 1'b1;
                            end
                            smsa_pkg::OP_WR_PTR:
                            begin
                                status_reg   <= ptr_we ? smsa_pkg::ST_DONE : smsa_pkg::ST_RANGE;
                                m_tvalid_reg <= 1'b1;
                            end
                            smsa_pkg::OP_WR_ROW:
                            begin
                                status_reg   <= row_we ? smsa_pkg::ST_DONE : smsa_pkg::ST_RANGE;
                                m_tvalid_reg <= 1'b1;
                            end
                            smsa_pkg::OP_WR_VAL:
                            begin
                                status_reg   <= val_we ? smsa_pkg::ST_DONE : smsa_pkg::ST_RANGE;
                                m_tvalid_reg <= 1'b1;
                            end
                            smsa_pkg::OP_RD_VAL:
                            begin
                                if (addr32 < NUM_NONZEROS)
                                begin
                                    status_reg <= smsa_pkg::ST_DONE;
                                    state_reg  <= S_VRD;
                                end
                                else
                                begin
                                    status_reg   <= smsa_pkg::ST_RANGE;
                                    m_tvalid_reg <= 1'b1;
                                end
                            end
                            smsa_pkg::OP_ACC:
                            begin
                                if ((32'(in_rdof) < NUM_DOFS) && (32'(in_cdof) < NUM_DOFS))
                                begin
                                    status_reg <= smsa_pkg::ST_DONE;
                                    state_reg  <= S_MAP_R;
                                end
                                else
                                begin
                                    status_reg   <= smsa_pkg::ST_RANGE;
                                    m_tvalid_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                status_reg   <= smsa_pkg::ST_DONE;
                                m_tvalid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_VRD:
                begin
                    rre_reg      <= val_rdata[VW-1:0];
                    rim_reg      <= val_rdata[2*VW-1:VW];
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_MAP_R:
                begin
                    mrow_reg  <= map_rdata;
                    state_reg <= S_MAP_C;
                end
                S_MAP_C:
                begin
                    // Skip order: constrained row, lower half, constrained column.
                    if ((mrow_reg == -18'sd1) || (rdof_reg > cdof_reg) || (mcol32 == -32'sd1))
                    begin
                        status_reg   <= smsa_pkg::ST_SKIP;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else if ((mcol32 < 0) || (mcol32 >= NUM_EQUATIONS))
                    begin
                        status_reg   <= smsa_pkg::ST_RANGE;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        mcol_reg  <= mcol32[PA-1:0];
                        state_reg <= S_PTR0;
                    end
                end
                S_PTR0:
                begin
                    // The start pointer read was issued in the previous cycle.
                    pos_reg   <= {ptr_rdata[WW-1], ptr_rdata};
                    state_reg <= S_PTR1;
                end
                S_PTR1:
                begin
                    stop_reg  <= {ptr_rdata[WW-1], ptr_rdata};
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (pos_reg >= stop_reg)
                    begin
                        status_reg   <= smsa_pkg::ST_MISS;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else if ((e32 < 0) || (e32 >= NUM_NONZEROS))
                    begin
                        status_reg   <= smsa_pkg::ST_RANGE;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        e_reg     <= e32[NA-1:0];
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if ({row_rdata[WW-1], row_rdata} == want)
                    begin
                        state_reg <= S_VAL;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + 19'sd1;
                        state_reg <= S_SCAN;
                    end
                end
                S_VAL:
                begin
                    acc_im_reg <= val_rdata[2*VW-1:VW];
                    state_reg  <= S_ADD_RE;
                end
                S_ADD_RE:
                begin
                    if (fadd_done)
                    begin
                        re_res_reg <= fadd_res;
                        state_reg  <= S_ADD_IM;
                    end
                end
                S_ADD_IM:
                begin
                    if (fadd_done)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, rim_reg, rre_reg, status_reg};

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("item taken during value clear");

    a_accept_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken before result");

    a_fadd_done_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        fadd_done |-> ((state_reg == S_ADD_RE) || (state_reg == S_ADD_IM)))
        else $error("adder result outside add states");

    a_result_not_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CMP) && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("result raised from row compare");

endmodule
